/* hdl/pspe_pkg.sv */
// Package for the power-series polynomial evaluator.
// Holds the payload and pipeline link types, fixed-point constants used by the
// cells, the output stage and the top level, and saturation helpers for the first two.
`default_nettype none

package pspe_pkg;

  // Default highest power supported by the cell chain.
  localparam int MAX_ORDER_DEF = 6;

  // Widths of the Q16.16 datapath.
  localparam int Q_W    = 32;
  localparam int IDX_W  = 3;
  localparam int PROD_W = 64;
  // Sum of the constant term and six shifted products stays well inside 52 bits.
  localparam int ACC_W  = 52;

  localparam logic [Q_W-1:0] ONE_Q = 32'h0001_0000;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_ORDER = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF0 = 3'd1;

  // Saturation index value meaning that no power has saturated.
  localparam logic [IDX_W-1:0] NO_SAT = 3'd0;

  localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'({1'b0, {(Q_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] Q_MIN = {{(ACC_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};

  typedef struct packed {
    logic              op;
    logic signed [31:0] x;
    logic              end_of_block;
  } pspe_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         term_index;
    logic               last;
    logic               overflow;
    logic               block_end;
  } pspe_out_t;

  // Per-sample state handed from one cell to the next.
  typedef struct packed {
    logic                     op;
    logic                     eob;
    logic [IDX_W-1:0]         n;
    logic signed [Q_W-1:0]    x;
    logic signed [Q_W-1:0]    pw;
    logic [IDX_W-1:0]         sat_idx;
    logic signed [ACC_W-1:0]  acc;
    logic signed [PROD_W-1:0] tprod;
  } pspe_link_t;

  function automatic logic sat_hit(input logic signed [ACC_W-1:0] v);
    return (v > Q_MAX) || (v < Q_MIN);
  endfunction

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [ACC_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > Q_MAX) begin
      r = {1'b0, {(Q_W-1){1'b1}}};
    end else if (v < Q_MIN) begin
      r = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/pspe_cell.sv */
// One cell of the power chain: builds x^IDX from x^(IDX-1) and the term product.
// Two register stages; depends on pspe_pkg.
`default_nettype none

module pspe_cell
  import pspe_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  parameter int IDX       = 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic signed [Q_W-1:0]       coef_i,
  input  wire logic                        vld_i,
  input  wire pspe_link_t                  link_i,
  input  wire logic [MAX_ORDER:0][Q_W-1:0] pows_i,
  output logic                             vld_o,
  output pspe_link_t                       link_o,
  output logic [MAX_ORDER:0][Q_W-1:0]      pows_o
);

  logic                        a_vld_r;
  pspe_link_t                  a_link_r, a_link_nxt;
  logic signed [PROD_W-1:0]    a_prod_r, a_prod_nxt;
  logic [MAX_ORDER:0][Q_W-1:0] a_pows_r;

  logic                        b_vld_r;
  pspe_link_t                  b_link_r, b_link_nxt;
  logic [MAX_ORDER:0][Q_W-1:0] b_pows_r, b_pows_nxt;

  logic                        active;
  logic signed [ACC_W-1:0]     p_shift;
  logic signed [Q_W-1:0]       pw_sat;
  logic                        hit;

  // Stage A: fold in the previous cell's term and multiply the power by x.
  always_comb begin
    a_link_nxt       = link_i;
    a_link_nxt.acc   = link_i.acc + ACC_W'(link_i.tprod >>> 16);
    a_link_nxt.tprod = '0;
    a_prod_nxt       = PROD_W'(link_i.pw) * PROD_W'(link_i.x);
  end

  // Stage B: truncate and saturate the power, then form coefficient times power.
  always_comb begin
    active     = (a_link_r.n >= IDX_W'(IDX));
    p_shift    = ACC_W'(a_prod_r >>> 16);
    hit        = sat_hit(p_shift);
    pw_sat     = sat_q(p_shift);
    b_link_nxt = a_link_r;
    b_pows_nxt = a_pows_r;
    b_pows_nxt[IDX] = pw_sat;
    if (active) begin
      b_link_nxt.pw    = pw_sat;
      b_link_nxt.tprod = PROD_W'(coef_i) * PROD_W'(pw_sat);
      if (hit && (a_link_r.sat_idx == NO_SAT)) begin
        b_link_nxt.sat_idx = IDX_W'(IDX);
      end
    end else begin
      b_link_nxt.tprod = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= vld_i;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_link_r <= a_link_nxt;
      a_prod_r <= a_prod_nxt;
      a_pows_r <= pows_i;
      b_link_r <= b_link_nxt;
      b_pows_r <= b_pows_nxt;
    end
  end

  assign vld_o  = b_vld_r;
  assign link_o = b_link_r;
  assign pows_o = b_pows_r;

endmodule

`default_nettype wire

/* hdl/pspe_out.sv */
// Output stage: finishes the polynomial sum and serializes the row of powers.
// Holds one sample's results while they are taken; depends on pspe_pkg.
`default_nettype none

module pspe_out
  import pspe_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        vld_i,
  input  wire pspe_link_t                  link_i,
  input  wire logic [MAX_ORDER:0][Q_W-1:0] pows_i,
  output logic                             take_o,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output pspe_out_t                        out_data
);

  localparam int IW = (MAX_ORDER < 2) ? 1 : $clog2(MAX_ORDER + 1);

  logic                        vld_r;
  logic [IDX_W-1:0]            cnt_r;
  logic                        op_r;
  logic                        eob_r;
  logic [IDX_W-1:0]            n_r;
  logic [IDX_W-1:0]            sat_idx_r;
  logic signed [Q_W-1:0]       val0_r;
  logic                        ovf0_r;
  logic [MAX_ORDER:0][Q_W-1:0] pows_r;

  logic signed [ACC_W-1:0]     sum;
  logic                        last;

  assign sum    = link_i.acc + ACC_W'(link_i.tprod >>> 16);
  assign last   = op_r ? (cnt_r == n_r) : 1'b1;
  assign take_o = !vld_r || (out_ready && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      cnt_r <= '0;
    end else if (take_o) begin
      vld_r <= vld_i;
      cnt_r <= '0;
    end else if (out_ready) begin
      cnt_r <= cnt_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take_o) begin
      op_r      <= link_i.op;
      eob_r     <= link_i.eob;
      n_r       <= link_i.n;
      sat_idx_r <= link_i.sat_idx;
      val0_r    <= sat_q(sum);
      ovf0_r    <= sat_hit(sum) || (link_i.sat_idx != NO_SAT);
      pows_r    <= pows_i;
    end
  end

  always_comb begin
    out_data            = '0;
    out_data.value      = op_r ? $signed(pows_r[cnt_r[IW-1:0]]) : val0_r;
    out_data.term_index = op_r ? cnt_r : '0;
    out_data.last       = last;
    out_data.overflow   = op_r ? ((sat_idx_r != NO_SAT) && (cnt_r >= sat_idx_r)) : ovf0_r;
    out_data.block_end  = last && eob_r;
  end

  assign out_valid = vld_r;

endmodule

`default_nettype wire

/* hdl/power_series_polynomial_eval_core.sv */
// Power-series polynomial evaluator, top level: registers, cell chain, output stage.
// Accepted transactions pass the register stages of every cell, then the output register.
// A new sample can enter every cycle while the output takes each result; op 0 gives one
// result per sample, op 1 holds the whole chain until all order+1 powers are taken.
// Reset (rst_n, synchronous, active low) empties the pipeline, clears order and
// all coefficients to zero. Depends on pspe_pkg, pspe_cell and pspe_out.
`default_nettype none

module power_series_polynomial_eval_core
  import pspe_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_idx,
  input  wire logic [Q_W-1:0]   cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pspe_in_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output pspe_out_t             out_data
);

  // Configuration registers. Writes must arrive only while the block is idle; the block
  // itself does not enforce this. The cells read the coefficients and order directly.
  logic [IDX_W-1:0]      order_r;
  logic signed [Q_W-1:0] coef_r [MAX_ORDER:0];
  logic [IDX_W-1:0]      n_clamped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= '0;
      for (int k = 0; k <= MAX_ORDER; k++) begin
        coef_r[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_idx == REG_ORDER) begin
        order_r <= cfg_wdata[IDX_W-1:0];
      end
      // Coefficients above the supported order have no storage; their writes
      // are dropped.
      for (int k = 0; k <= MAX_ORDER; k++) begin
        if (cfg_idx == REG_COEF0 + IDX_W'(k)) begin
          coef_r[k] <= cfg_wdata;
        end
      end
    end
  end

  // An order above the cell count is treated as the highest supported order.
  assign n_clamped = (order_r > IDX_W'(MAX_ORDER)) ? IDX_W'(MAX_ORDER) : order_r;

  // The whole chain advances together whenever the output stage can take the
  // sample at the end of it. A stalled output therefore holds every stage,
  // and the input is ready exactly when the chain moves.
  logic                        adv;
  logic                        vld   [MAX_ORDER:0];
  pspe_link_t                  lk    [MAX_ORDER:0];
  logic [MAX_ORDER:0][Q_W-1:0] pows  [MAX_ORDER:0];
  pspe_link_t                  lk_head;
  logic [MAX_ORDER:0][Q_W-1:0] pows_head;

  assign in_ready = adv;

  // The chain starts with x^0 = 1.0 so that the first cell produces x itself
  // through the same multiply and shift as every other power.
  always_comb begin
    lk_head.op      = in_data.op;
    lk_head.eob     = in_data.end_of_block;
    lk_head.n       = n_clamped;
    lk_head.x       = in_data.x;
    lk_head.pw      = $signed(ONE_Q);
    lk_head.sat_idx = NO_SAT;
    lk_head.acc     = ACC_W'(coef_r[0]);
    lk_head.tprod   = '0;
    pows_head       = '0;
    pows_head[0]    = ONE_Q;
  end

  assign vld[0]  = in_valid;
  assign lk[0]   = lk_head;
  assign pows[0] = pows_head;

  // Cell j computes x^j and coef_j * x^j; cells above the programmed order
  // pass the sample through without contributing.
  for (genvar g = 1; g <= MAX_ORDER; g++) begin : g_cell
    pspe_cell #(
      .MAX_ORDER (MAX_ORDER),
      .IDX       (g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .coef_i (coef_r[g]),
      .vld_i  (vld[g-1]),
      .link_i (lk[g-1]),
      .pows_i (pows[g-1]),
      .vld_o  (vld[g]),
      .link_o (lk[g]),
      .pows_o (pows[g])
    );
  end

  // The output stage adds the last term, saturates the sum, and in op 1 walks
  // the stored powers one transaction at a time.
  pspe_out #(
    .MAX_ORDER (MAX_ORDER)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_i     (vld[MAX_ORDER]),
    .link_i    (lk[MAX_ORDER]),
    .pows_i    (pows[MAX_ORDER]),
    .take_o    (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* bench/power_series_polynomial_eval_core_tb.sv */
// Self-checking testbench for power_series_polynomial_eval_core.
// Drives Q16.16 samples under random flow control, predicts every result in a
// scoreboard class and compares field by field. Depends on pspe_pkg and the core.

module power_series_polynomial_eval_core_tb;
  import pspe_pkg::*;

  // Operation codes carried in the op field of an input transaction.
  localparam logic OP_EVAL = 1'b0;
  localparam logic OP_ROW  = 1'b1;

  // Q16.16 extremes.
  localparam logic [31:0] Q_TOP    = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_BOTTOM = 32'h8000_0000;

  // The pipeline is 2*MAX_ORDER+1 deep, so this many quiet cycles after the
  // last result guarantees nothing is still in flight.
  localparam int SETTLE_CYCLES  = 2 * MAX_ORDER_DEF + 4;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int RAND_SEGMENTS  = 6;
  localparam int SEGMENT_ITEMS  = 18;

  // Flow-control regimes: which side idles more.
  typedef enum logic [1:0] {PACE_RX_HEAVY, PACE_TX_HEAVY, PACE_FREE} pace_t;

  // Keeps a mirror of the configuration registers, expands every accepted
  // sample into the results the core owes for it, and checks them in order.
  class poly_scoreboard;
    logic [2:0]  order_reg;
    logic [31:0] coef_reg [7];
    pspe_out_t   owed[$];
    int          errors;

    function new();
      order_reg = '0;
      foreach (coef_reg[i]) coef_reg[i] = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      if (idx == REG_ORDER) begin
        order_reg = data[2:0];
      end else begin
        coef_reg[idx - REG_COEF0] = data;
      end
    endfunction

    // Appends one predicted result at the tail of the queue.
    function void owe(pspe_out_t r);
      owed.insert(owed.size(), r);
    endfunction

    // Saturates to the signed 32-bit range and reports whether it had to.
    static function logic signed [63:0] clip_q(input logic signed [63:0] v, output bit hit);
      hit = 1'b1;
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      hit = 1'b0;
      return v;
    endfunction

    function void note_sample(pspe_in_t s);
      logic signed [63:0] pw [7];
      bit                 sticky [7];
      logic signed [63:0] xs;
      logic signed [63:0] acc;
      logic signed [63:0] cj;
      bit                 hit;
      int                 n;
      int                 j;
      pspe_out_t          r;
      n = order_reg;
      if (n > MAX_ORDER_DEF) n = MAX_ORDER_DEF;
      xs = {{32{s.x[31]}}, s.x};
      pw[0] = 64'sh1_0000;
      sticky[0] = 1'b0;
      // Each power is built from the saturated previous one; once a power
      // saturates the overflow mark carries to every higher power.
      for (j = 1; j <= n; j++) begin
        hit = 1'b0;
        if (j == 1) begin
          pw[j] = xs;
        end else begin
          pw[j] = clip_q((pw[j-1] * xs) >>> 16, hit);
        end
        sticky[j] = sticky[j-1] | hit;
      end
      if (s.op == OP_EVAL) begin
        acc = {{32{coef_reg[0][31]}}, coef_reg[0]};
        for (j = 1; j <= n; j++) begin
          cj = {{32{coef_reg[j][31]}}, coef_reg[j]};
          acc = acc + ((cj * pw[j]) >>> 16);
        end
        acc = clip_q(acc, hit);
        r.value      = acc[31:0];
        r.term_index = 3'd0;
        r.last       = 1'b1;
        r.overflow   = sticky[n] | hit;
        r.block_end  = s.end_of_block;
        owe(r);
      end else begin
        for (j = 0; j <= n; j++) begin
          r.value      = pw[j][31:0];
          r.term_index = 3'(j);
          r.last       = (j == n);
          r.overflow   = sticky[j];
          r.block_end  = (j == n) ? s.end_of_block : 1'b0;
          owe(r);
        end
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(pspe_out_t got);
      pspe_out_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = owed.pop_front();
      compare_field("value", want.value, got.value);
      compare_field("term_index", want.term_index, got.term_index);
      compare_field("last", want.last, got.last);
      compare_field("overflow", want.overflow, got.overflow);
      compare_field("block_end", want.block_end, got.block_end);
    endfunction
  endclass

  // Every input of the core starts at a known value.
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_idx   = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  pspe_in_t    in_data   = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  pspe_out_t   out_data;

  pace_t          pace = PACE_RX_HEAVY;
  int             cycle_count = 0;
  logic [31:0]    coef_plan [7];
  logic [31:0]    probe [8];
  poly_scoreboard book;

  power_series_polynomial_eval_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random according to the current regime. It is
  // driven at the clock edge, so the core sees a stable ready all cycle.
  always @(posedge clk) begin
    case (pace)
      PACE_RX_HEAVY: out_ready <= ($urandom_range(0, 99) >= 74);
      PACE_TX_HEAVY: out_ready <= ($urandom_range(0, 99) >= 38);
      default:       out_ready <= 1'b1;
    endcase
  end

  // Results are sampled at the edge where the transaction completes; the
  // values read here are the ones the core presented before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      book.check_result(out_data);
    end
  end

  // Watchdog: a hang or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("power_series_polynomial_eval_core regression: fail");
      $finish;
    end
  end

  // Offers one sample, with random idle cycles in front of it, and holds it
  // until the core takes it. Valid is left high so that back-to-back
  // transactions need no extra cycle; the next call lowers it for its idle cycles, and a drain lowers it.
  task automatic send_sample(input logic op, input logic [31:0] x, input logic eob);
    pspe_in_t s;
    int       pct;
    s.op = op;
    s.x = x;
    s.end_of_block = eob;
    pct = (pace == PACE_RX_HEAVY) ? 38 : (pace == PACE_TX_HEAVY) ? 74 : 0;
    while ($urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_sample(s);
  endtask

  // Stops the sender and waits until every owed result has come out and the
  // pipeline has had time to empty.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (book.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the order register and all seven coefficients from coef_plan.
  task automatic load_config(input logic [2:0] ord);
    int i;
    cfg_we <= 1'b1;
    cfg_idx <= REG_ORDER;
    cfg_wdata <= {29'd0, ord};
    @(posedge clk);
    book.write_reg(REG_ORDER, {29'd0, ord});
    for (i = 0; i < 7; i++) begin
      cfg_idx <= REG_COEF0 + 3'(i);
      cfg_wdata <= coef_plan[i];
      @(posedge clk);
      book.write_reg(REG_COEF0 + 3'(i), coef_plan[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Coefficients: half of them moderate values so sums stay in range, plus full
  // random words and the two extremes to force saturation.
  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      1:       return $urandom();
      2:       return $urandom_range(0, 1) ? Q_TOP : Q_BOTTOM;
      default: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
    endcase
  endfunction

  // Samples: half of them within +/-2.0 where high powers stay meaningful,
  // some fractions near zero, some full-range words, and a few landmarks.
  function automatic logic [31:0] pick_sample();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    if (sel < 7) return $urandom_range(0, 32'h0001_0000) - 32'h0000_8000;
    if (sel < 9) return $urandom();
    case ($urandom_range(0, 4))
      0:       return Q_TOP;
      1:       return Q_BOTTOM;
      2:       return ONE_Q;
      3:       return -ONE_Q;
      default: return '0;
    endcase
  endfunction

  initial begin
    int seg;
    int k;
    book = new();

    // Synchronous reset is held at the start, then released for good.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. First the configuration left by reset: order zero and
    // all coefficients zero.
    pace = PACE_RX_HEAVY;
    send_sample(OP_ROW, 32'h0003_8000, 1'b1);
    send_sample(OP_EVAL, 32'h0003_8000, 1'b0);

    // Full order with extreme and simple coefficients. Each landmark sample
    // goes through both operations: zero, plus and minus one, both extremes
    // (whose powers saturate at once), two, a half and the smallest negative.
    wait_drained();
    coef_plan[0] = Q_TOP;
    coef_plan[1] = Q_BOTTOM;
    coef_plan[2] = ONE_Q;
    coef_plan[3] = -ONE_Q;
    coef_plan[4] = Q_TOP;
    coef_plan[5] = Q_BOTTOM;
    coef_plan[6] = 32'h0000_8000;
    load_config(3'd6);
    probe[0] = '0;
    probe[1] = ONE_Q;
    probe[2] = -ONE_Q;
    probe[3] = Q_TOP;
    probe[4] = Q_BOTTOM;
    probe[5] = 32'h0002_0000;
    probe[6] = 32'h0000_8000;
    probe[7] = 32'hFFFF_FFFF;
    for (k = 0; k < 8; k++) begin
      send_sample(OP_EVAL, probe[k], k[0]);
      send_sample(OP_ROW, probe[k], ~k[0]);
    end

    // An order of seven is beyond the limit and must behave as six.
    wait_drained();
    coef_plan[0] = 32'h0001_8000;
    coef_plan[1] = 32'hFFFF_C000;
    coef_plan[2] = 32'h0000_4000;
    coef_plan[3] = 32'h0002_0000;
    coef_plan[4] = 32'hFFFE_0000;
    coef_plan[5] = 32'h0000_1000;
    coef_plan[6] = ONE_Q;
    load_config(3'd7);
    send_sample(OP_EVAL, 32'h0001_8000, 1'b1);
    send_sample(OP_ROW, 32'hFFFE_0000, 1'b1);

    // Order zero: only the constant term, and a row of a single power.
    wait_drained();
    for (k = 0; k < 7; k++) coef_plan[k] = Q_BOTTOM;
    load_config(3'd0);
    send_sample(OP_EVAL, Q_TOP, 1'b0);
    send_sample(OP_ROW, Q_BOTTOM, 1'b1);

    // Random part. Each segment starts from an empty pipeline with a fresh
    // configuration; the regime moves from a slow receiver to a slow sender
    // and finally to no idling at all.
    for (seg = 0; seg < RAND_SEGMENTS; seg++) begin
      wait_drained();
      pace = (seg < 2) ? PACE_RX_HEAVY : (seg < 4) ? PACE_TX_HEAVY : PACE_FREE;
      for (k = 0; k < 7; k++) coef_plan[k] = pick_coef();
      load_config(3'($urandom_range(0, 7)));
      repeat (SEGMENT_ITEMS) begin
        send_sample(1'($urandom_range(0, 1)), pick_sample(), ($urandom_range(0, 7) == 0));
      end
    end

    wait_drained();
    if (book.errors == 0 && book.owed.size() == 0) begin
      $display("power_series_polynomial_eval_core regression: pass");
    end else begin
      $display("power_series_polynomial_eval_core regression: fail");
    end
    $finish;
  end

endmodule
